[sv/quoted_nested_list_splitter_defines.svh]
// Assertion macros for the list splitter.
`ifndef QUOTED_NESTED_LIST_SPLITTER_DEFINES_SVH
`define QUOTED_NESTED_LIST_SPLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define QNLS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qnls assertion failed");
// checked at every edge, reset included
`define QNLS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("qnls assertion failed");
`else
`define QNLS_ASSERT(label, prop)
`define QNLS_ASSERT_ALWAYS(label, prop)
`endif

`endif

[sv/qnls_pkg.sv]
package qnls_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef struct packed {
    logic       depth_saturated;
    logic       ends_final;
    logic       in_literal;
    logic       is_separator;
    logic [7:0] char_out;
  } result_t;

endpackage

[sv/qnls_scan.sv]
`include "quoted_nested_list_splitter_defines.svh"

module qnls_scan
  import qnls_pkg::*;
#(
  parameter int MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output result_t    result_o
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam logic [DW-1:0] DepthMax = DW'(MAX_DEPTH);

  typedef enum logic [1:0] {
    MODE_OUT  = 2'd0,
    MODE_IN   = 2'd1,
    MODE_PEND = 2'd2
  } mode_e;

  mode_e         mode_q, mode_d;
  logic [DW-1:0] paren_q, paren_d;
  logic [DW-1:0] bracket_q, bracket_d;

  logic is_quote;
  logic outside;
  logic lit, sep, sat;

  assign is_quote = (char_i == CH_QUOTE);

  always_comb begin
    mode_d    = mode_q;
    paren_d   = paren_q;
    bracket_d = bracket_q;
    outside   = 1'b0;
    lit       = 1'b0;
    sep       = 1'b0;
    sat       = 1'b0;

    case (mode_q)
      MODE_IN: begin
        lit = 1'b1;
        if (is_quote) mode_d = MODE_PEND;
      end
      MODE_PEND: begin
        // a second quote is an escaped pair, anything else closed the literal
        if (is_quote) begin
          lit    = 1'b1;
          mode_d = MODE_IN;
        end else begin
          outside = 1'b1;
        end
      end
      default: outside = 1'b1;
    endcase

    if (outside) begin
      mode_d = MODE_OUT;
      case (char_i)
        CH_QUOTE: begin
          lit    = 1'b1;
          mode_d = MODE_IN;
        end
        CH_LPAREN: begin
          if (paren_q >= DepthMax) sat = 1'b1;
          else paren_d = paren_q + 1'b1;
        end
        CH_RPAREN: begin
          if (paren_q == '0) sat = 1'b1;
          else paren_d = paren_q - 1'b1;
        end
        CH_LBRACK: begin
          if (bracket_q >= DepthMax) sat = 1'b1;
          else bracket_d = bracket_q + 1'b1;
        end
        CH_RBRACK: begin
          if (bracket_q == '0) sat = 1'b1;
          else bracket_d = bracket_q - 1'b1;
        end
        CH_COMMA: begin
          sep = (paren_q == '0) && (bracket_q == '0);
        end
        default: ;
      endcase
    end

    // end of list: back to reset state
    if (last_i) begin
      mode_d    = MODE_OUT;
      paren_d   = '0;
      bracket_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OUT;
      paren_q   <= '0;
      bracket_q <= '0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      paren_q   <= paren_d;
      bracket_q <= bracket_d;
    end
  end

  assign result_o.char_out        = char_i;
  assign result_o.is_separator    = sep;
  assign result_o.in_literal      = lit;
  assign result_o.ends_final      = last_i & ~sep;
  assign result_o.depth_saturated = sat;

  `QNLS_ASSERT(a_last_clears_state,
    advance_i && last_i |=> mode_q == MODE_OUT && paren_q == '0 && bracket_q == '0)
  `QNLS_ASSERT(a_depth_bound, paren_q <= DepthMax && bracket_q <= DepthMax)
  `QNLS_ASSERT(a_sep_at_top_level,
    advance_i && sep |-> paren_q == '0 && bracket_q == '0 && !lit)
  `QNLS_ASSERT(a_sat_holds_depth,
    advance_i && sat && !last_i |=> $stable(paren_q) && $stable(bracket_q))

endmodule

[sv/qnls_out_reg.sv]
module qnls_out_reg
  import qnls_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_valid_i,
  output logic    load_ready_o,
  input  result_t load_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q;
  result_t data_q;

  // refill in the same cycle the held word is taken
  assign load_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[sv/quoted_nested_list_splitter.sv]
// Quote-aware comma splitter for an expression list, one character per word.
// Input stream: tdata carries the character, tlast flags the final character
// of the list. Output stream: one word per input word, tdata the character
// passed through, tuser the flags: top-level comma, inside a quoted literal,
// end of a non-empty final expression, depth counter held at a bound.
// Single quotes open literals; a doubled quote inside one is an escaped quote.
// Parenthesis and bracket depths count up to MAX_DEPTH and hold at the bounds.
// A word accepted from the input is held in the input register, classified
// against the quote and depth state, and written to the output register once
// that register is free or its word is being taken.
// Throughput: one word per cycle while the receiver is ready; the state update
// is a single pass of compares and counter steps from input to output register.
// State returns to its reset values after each word marked last.
// Reset clears the quote state, both depths and both register valid flags.
// When the receiver stalls, the output word holds, the input register fills,
// and then s_axis_tready drops until the output is taken.
`include "quoted_nested_list_splitter_defines.svh"

module quoted_nested_list_splitter
  import qnls_pkg::*;
#(
  parameter int MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic [3:0] m_axis_tuser    // [0] is_separator, [1] in_literal,
                                     // [2] ends_final, [3] depth_saturated
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       load_ready;
  logic       advance;
  result_t    scan_res;
  result_t    out_res;

  assign advance       = in_valid_q && load_ready;
  assign s_axis_tready = !in_valid_q || load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  qnls_scan #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .result_o (scan_res)
  );

  qnls_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(in_valid_q),
    .load_ready_o(load_ready),
    .load_data_i (scan_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = out_res.char_out;
  assign m_axis_tuser = {out_res.depth_saturated, out_res.ends_final,
                         out_res.in_literal, out_res.is_separator};

  `QNLS_ASSERT(a_sep_not_literal,
    m_axis_tvalid |-> !(m_axis_tuser[0] && (m_axis_tuser[1] || m_axis_tuser[2])))
  `QNLS_ASSERT(a_input_moves_on,
    in_valid_q && load_ready |=> m_axis_tvalid)

endmodule

[tb/quoted_nested_list_splitter_checker.sv]
module quoted_nested_list_splitter_checker
  import qnls_pkg::*;
#(
  parameter int MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
  input  logic       s_axis_tlast,   // is_last
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] char_out
  input  logic [3:0] m_axis_tuser,   // [0] is_separator, [1] in_literal,
                                     // [2] ends_final, [3] depth_saturated
  output int         mismatch_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    QUOTE_OUT  = 2'd0,
    QUOTE_IN   = 2'd1,
    QUOTE_PEND = 2'd2
  } quote_mode_e;

  quote_mode_e qmode;
  logic [8:0]  paren_lvl;
  logic [8:0]  brack_lvl;
  logic        seg_open;

  result_t expected_words[$];
  int      mismatches = 0;
  int      words_seen = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(string what, int exp_val, int got_val);
    // print is capped so a broken build cannot flood the log
    if (mismatches < 200) begin
      $display("%0t word %0d %s: expected %0h got %0h", $realtime, words_seen, what,
               exp_val, got_val);
    end
    mismatches++;
  endtask

  task automatic check_field(string what, logic [7:0] exp_val, logic [7:0] got_val);
    if (exp_val !== got_val) begin
      report_mismatch(what, int'(exp_val), int'(got_val));
    end
  endtask

  function automatic void clear_state();
    qmode     = QUOTE_OUT;
    paren_lvl = '0;
    brack_lvl = '0;
    seg_open  = 1'b0;
  endfunction

  function automatic logic [8:0] step_level(logic [8:0] lvl, logic up, output logic held);
    held = 1'b0;
    if (up) begin
      if (lvl >= 9'(MAX_DEPTH)) begin
        held = 1'b1;
        return 9'(MAX_DEPTH);
      end
      return lvl + 9'd1;
    end
    if (lvl == '0) begin
      held = 1'b1;
      return '0;
    end
    return lvl - 9'd1;
  endfunction

  function automatic result_t predict_word(logic [7:0] c, logic last);
    result_t r;
    logic    outside;
    logic    held;
    r          = '0;
    r.char_out = c;
    outside    = 1'b0;
    held       = 1'b0;
    case (qmode)
      QUOTE_IN: begin
        r.in_literal = 1'b1;
        if (c == CH_QUOTE) qmode = QUOTE_PEND;
      end
      QUOTE_PEND: begin
        // second quote of an escaped pair, or the previous quote closed it
        if (c == CH_QUOTE) begin
          r.in_literal = 1'b1;
          qmode        = QUOTE_IN;
        end else begin
          qmode   = QUOTE_OUT;
          outside = 1'b1;
        end
      end
      default: begin
        qmode   = QUOTE_OUT;
        outside = 1'b1;
      end
    endcase
    if (outside) begin
      if (c == CH_QUOTE) begin
        r.in_literal = 1'b1;
        qmode        = QUOTE_IN;
      end else if (c == CH_LPAREN) begin
        paren_lvl = step_level(paren_lvl, 1'b1, held);
      end else if (c == CH_RPAREN) begin
        paren_lvl = step_level(paren_lvl, 1'b0, held);
      end else if (c == CH_LBRACK) begin
        brack_lvl = step_level(brack_lvl, 1'b1, held);
      end else if (c == CH_RBRACK) begin
        brack_lvl = step_level(brack_lvl, 1'b0, held);
      end else if (c == CH_COMMA && paren_lvl == '0 && brack_lvl == '0) begin
        r.is_separator = 1'b1;
      end
    end
    r.depth_saturated = held;
    seg_open = !r.is_separator;
    if (last) begin
      r.ends_final = seg_open;
      clear_state();
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      clear_state();
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'({m_axis_tuser, m_axis_tdata});
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 0, int'(got));
        end else begin
          want = expected_words.pop_front();
          check_field("char_out", want.char_out, got.char_out);
          check_field("is_separator", 8'(want.is_separator), 8'(got.is_separator));
          check_field("in_literal", 8'(want.in_literal), 8'(got.in_literal));
          check_field("ends_final", 8'(want.ends_final), 8'(got.ends_final));
          check_field("depth_saturated", 8'(want.depth_saturated),
                      8'(got.depth_saturated));
        end
        words_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words = {expected_words, predict_word(s_axis_tdata, s_axis_tlast)};
      end
    end
    pending_o <= expected_words.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  import qnls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_BOUND  = 255;
  localparam int RANDOM_WORDS = 550;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] char_byte
  logic       s_axis_tlast  = 1'b0; // is_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [7:0] char_out
  logic [3:0] m_axis_tuser;         // [0] is_separator, [1] in_literal,
                                    // [2] ends_final, [3] depth_saturated
  int         mismatch_count;
  int         pending;

  logic [7:0] list_bytes[$];
  int         burst_left = 0;
  int         rx_mode    = 0;
  int         rx_left    = 0;
  int         rx_tick    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  quoted_nested_list_splitter #(
    .MAX_DEPTH(DEPTH_BOUND)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  quoted_nested_list_splitter_checker #(
    .MAX_DEPTH(DEPTH_BOUND)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .mismatch_count_o(mismatch_count),
    .pending_o(pending)
  );

  // receiver: stretches of always-ready, mostly-ready, mostly-stalled, periodic
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(8, 60);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_tick % 5 != 0);
    endcase
  end

  function automatic void add_byte(logic [7:0] b);
    list_bytes = {list_bytes, b};
  endfunction

  task automatic send_word(logic [7:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_bytes();
    foreach (list_bytes[i]) send_word(list_bytes[i], i == list_bytes.size() - 1);
  endtask

  task automatic send_text(string s);
    list_bytes.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_bytes();
  endtask

  function automatic logic [7:0] any_but_quote();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  // one expression list: mostly well formed, some with broken nesting,
  // stray bytes, trailing commas or an open literal
  task automatic gen_list();
    int         n_expr;
    int         n_tok;
    int         n_chr;
    bit         broken;
    logic [7:0] closers[$];
    list_bytes.delete();
    broken = ($urandom_range(0, 4) == 0);
    n_expr = $urandom_range(1, 5);
    for (int e = 0; e < n_expr; e++) begin
      if (e > 0) add_byte(CH_COMMA);
      n_tok = $urandom_range(0, 5);
      for (int t = 0; t < n_tok; t++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            n_chr = $urandom_range(1, 4);
            repeat (n_chr) begin
              add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                            : 8'($urandom_range(8'h30, 8'h39)));
            end
          end
          3: begin
            add_byte(CH_QUOTE);
            n_chr = $urandom_range(0, 4);
            repeat (n_chr) begin
              if ($urandom_range(0, 3) == 0) begin
                add_byte(CH_QUOTE);
                add_byte(CH_QUOTE);
              end else begin
                add_byte(any_but_quote());
              end
            end
            add_byte(CH_QUOTE);
          end
          4: begin
            add_byte(CH_LPAREN);
            closers = {closers, CH_RPAREN};
          end
          5: begin
            add_byte(CH_LBRACK);
            closers = {closers, CH_RBRACK};
          end
          6: if (closers.size() != 0) add_byte(closers.pop_back());
          7: add_byte((closers.size() != 0) ? CH_COMMA : 8'h20);
          8: add_byte(8'($urandom_range(8'h20, 8'h7E)));
          default: add_byte(broken ? 8'($urandom_range(0, 255)) : 8'h2B);
        endcase
      end
      if (!broken) begin
        while (closers.size() != 0) add_byte(closers.pop_back());
      end
    end
    if (broken) begin
      case ($urandom_range(0, 3))
        0:       add_byte(CH_COMMA);
        1:       add_byte(CH_QUOTE);
        2:       add_byte($urandom_range(0, 1) ? CH_RPAREN : CH_RBRACK);
        default: ;
      endcase
    end
    if (list_bytes.size() == 0) add_byte(8'($urandom_range(0, 255)));
  endtask

  // both depths driven past the bound, then partly unwound
  task automatic send_deep_list();
    list_bytes.delete();
    repeat (DEPTH_BOUND + 2) add_byte(CH_LPAREN);
    add_byte(8'h61);
    repeat (DEPTH_BOUND + 2) add_byte(CH_LBRACK);
    repeat (3) add_byte(CH_RBRACK);
    add_byte(CH_COMMA);
    add_byte(CH_RPAREN);
    add_byte(8'h7A);
    send_bytes();
  endtask

  initial begin
    int random_sent;
    int waited;
    random_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nested commas, escaped quote, quote pending at the last word
    send_text("f(a,[b]),'it''s'");
    // closers at depth zero
    send_text(")]");
    // literal closed right before a trailing comma
    send_text("'q',");
    // literal never closed
    send_text("'ab");
    // lone comma as the whole list
    send_text(",");
    list_bytes.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_bytes();

    send_deep_list();
    while (random_sent < RANDOM_WORDS) begin
      gen_list();
      send_bytes();
      random_sent += list_bytes.size();
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending != 0) $display("%0d expected words never arrived", pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for the splitter");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
